>>> hw/rtl/kidts_pkg.sv
// ----------------------------------------------------------------------------
// Key ID table search package
// Shared sizes, command and status codes, sequencer states and the compare
// result type used by the key ID table search core.
// ----------------------------------------------------------------------------
package kidts_pkg;

  // Table and ID sizes.
  localparam int TABLE_DEPTH = 64;
  localparam int ID_BITS     = 64;
  localparam int HALF_BITS   = ID_BITS / 2;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Commands carried by an input transaction.
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_ATTACH = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  // Status codes carried by a result transaction.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_SHIFT  = 2'd2
  } state_t;

  // Outcome of comparing one table entry against the query.
  typedef struct packed {
    logic hit;
    logic sub;
  } match_t;

endpackage

>>> hw/rtl/kidts_id_cmp.sv
// ----------------------------------------------------------------------------
// Key ID entry compare
// Tests one table entry against a query ID: the primary ID first, then the
// subkey ID when it is not zero. A full match or a short-ID match counts.
// ----------------------------------------------------------------------------
module kidts_id_cmp
  import kidts_pkg::*;
(
  input  logic [ID_BITS-1:0] primary_id,
  input  logic [ID_BITS-1:0] subkey_id,
  input  logic [ID_BITS-1:0] query_id,
  output match_t             result
);

  logic prim_full;
  logic prim_short;
  logic sub_full;
  logic sub_short;
  logic sub_present;

  // The short form compares the stored low half with the query's high half.
  assign prim_full   = (primary_id == query_id);
  assign prim_short  = (primary_id[HALF_BITS-1:0] == query_id[ID_BITS-1 -: HALF_BITS]);
  assign sub_full    = (subkey_id == query_id);
  assign sub_short   = (subkey_id[HALF_BITS-1:0] == query_id[ID_BITS-1 -: HALF_BITS]);
  assign sub_present = (subkey_id != '0);

  // The primary ID takes priority over the subkey ID.
  always_comb begin
    result.hit = 1'b0;
    result.sub = 1'b0;
    if (prim_full || prim_short) begin
      result.hit = 1'b1;
    end else if (sub_present && (sub_full || sub_short)) begin
      result.hit = 1'b1;
      result.sub = 1'b1;
    end
  end

endmodule

>>> hw/rtl/key_id_table_search_core.sv
// Add and attach: the result is registered in the cycle after the input transaction.
// Lookup: entries are read in turn from start_index to the match or the table
// end through the single read port of the entry memory.
// Remove: a lookup from entry 0, then every entry after the match is moved
// down one place. One command at a time; in_ready is low while a command or
// result is pending. Reset clears the state, the entry count and the pending and output-valid flags.
// ----------------------------------------------------------------------------
// Key ID table search core
// Compacted table of primary and subkey IDs with append, attach, lookup and
// remove commands, walked by a small sequencer over an entry memory with one read port.
// ----------------------------------------------------------------------------
module key_id_table_search_core
  import kidts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [ID_BITS-1:0] in_key_id,
  input  logic [IDX_W-1:0]   in_start_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_match_index,
  output logic               out_matched_subkey,
  output logic [CNT_W-1:0]   out_entry_count
);

  // Entry storage.
  logic [ID_BITS-1:0] prim_mem [TABLE_DEPTH];
  logic [ID_BITS-1:0] sub_mem  [TABLE_DEPTH];

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [ID_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_index_r, out_index_nxt;
  logic               out_sub_r, out_sub_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ID_BITS-1:0] prim_rd_r;
  logic [ID_BITS-1:0] sub_rd_r;
  logic               prim_we;
  logic               sub_we;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_BITS-1:0] prim_wd;
  logic [ID_BITS-1:0] sub_wd;
  logic               in_fire;
  match_t             cmp;

  assign in_ready           = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire            = in_valid && in_ready;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_match_index    = out_index_r;
  assign out_matched_subkey = out_sub_r;
  assign out_entry_count    = out_count_r;

  // Shared compare unit on the registered read data.
  kidts_id_cmp u_cmp (
    .primary_id (prim_rd_r),
    .subkey_id  (sub_rd_r),
    .query_id   (key_r),
    .result     (cmp)
  );

  // Entry memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (prim_we) begin
      prim_mem[wr_addr] <= prim_wd;
    end
    if (sub_we) begin
      sub_mem[wr_addr] <= sub_wd;
    end
    if (rd_en) begin
      prim_rd_r <= prim_mem[rd_addr];
      sub_rd_r  <= sub_mem[rd_addr];
    end
  end

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_sub_r    <= out_sub_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Sequencer: next state, memory access and result.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    wr_idx_nxt     = wr_idx_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_sub_nxt    = out_sub_r;
    out_count_nxt  = out_count_r;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[IDX_W-1:0];
    prim_we        = 1'b0;
    sub_we         = 1'b0;
    wr_addr        = wr_idx_r;
    prim_wd        = prim_rd_r;
    sub_wd         = sub_rd_r;

    // A result transaction completes.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = cmd_t'(in_command);
          key_nxt        = in_key_id;
          out_sub_nxt    = 1'b0;
          out_index_nxt  = '0;
          out_status_nxt = ST_OK;
          case (cmd_t'(in_command))
            CMD_LOOKUP: begin
              rd_idx_nxt = {1'b0, in_start_index};
              state_nxt  = S_SEARCH;
            end
            CMD_REMOVE: begin
              rd_idx_nxt = '0;
              state_nxt  = S_SEARCH;
            end
            CMD_ADD: begin
              if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                out_status_nxt = ST_FULL;
                out_count_nxt  = count_r;
              end else begin
                prim_we       = 1'b1;
                sub_we        = 1'b1;
                wr_addr       = count_r[IDX_W-1:0];
                prim_wd       = in_key_id;
                sub_wd        = '0;
                out_index_nxt = count_r[IDX_W-1:0];
                count_nxt     = count_r + 1'b1;
                out_count_nxt = count_r + 1'b1;
              end
              out_valid_nxt = 1'b1;
            end
            default: begin
              // Attach a subkey ID to the last entry.
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                sub_we        = 1'b1;
                wr_addr       = IDX_W'(count_r - 1'b1);
                sub_wd        = in_key_id;
                out_index_nxt = IDX_W'(count_r - 1'b1);
              end
              out_count_nxt = count_r;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (pend_r && cmp.hit) begin
          // Match on the entry whose data was read last cycle.
          out_index_nxt  = cmp_idx_r;
          out_sub_nxt    = cmp.sub;
          out_status_nxt = ST_OK;
          if (cmd_r == CMD_LOOKUP) begin
            out_count_nxt = count_r;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            rd_idx_nxt = {1'b0, cmp_idx_r} + 1'b1;
            state_nxt  = S_SHIFT;
          end
        end else if (rd_idx_r < count_r) begin
          rd_en       = 1'b1;
          pend_nxt    = 1'b1;
          cmp_idx_nxt = rd_idx_r[IDX_W-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end else begin
          out_status_nxt = ST_NOT_FOUND;
          out_index_nxt  = '0;
          out_sub_nxt    = 1'b0;
          out_count_nxt  = count_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_SHIFT: begin
        // Write the entry read last cycle one place down.
        if (pend_r) begin
          prim_we = 1'b1;
          sub_we  = 1'b1;
          wr_addr = wr_idx_r;
          prim_wd = prim_rd_r;
          sub_wd  = sub_rd_r;
        end
        if (rd_idx_r < count_r) begin
          rd_en      = 1'b1;
          pend_nxt   = 1'b1;
          wr_idx_nxt = IDX_W'(rd_idx_r - 1'b1);
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else if (!pend_r) begin
          count_nxt     = count_r - 1'b1;
          out_count_nxt = count_r - 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
